// File: rtl/core/hrlp_pkg.sv
// Types and constants shared by the HTTP request-line parser.
package hrlp_pkg;

  // Width of the running byte offset; offset fields carry its low 16 bits.
  localparam int OFFSET_WIDTH = 16;

  localparam logic [1:0] STATUS_MORE    = 2'd0;
  localparam logic [1:0] STATUS_DONE    = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  localparam logic [1:0] METHOD_UNKNOWN = 2'd0;
  localparam logic [1:0] METHOD_GET     = 2'd1;
  localparam logic [1:0] METHOD_POST    = 2'd2;
  localparam logic [1:0] METHOD_HEAD    = 2'd3;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [31:0] LETTERS_GET  = 32'h47455400;
  localparam logic [31:0] LETTERS_POST = 32'h504F5354;
  localparam logic [31:0] LETTERS_HEAD = 32'h48454144;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } hrlp_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  method_kind;
    logic [15:0] uri_first;
    logic [15:0] uri_last;
  } hrlp_out_t;

endpackage

// File: rtl/core/http_request_line_parser.sv
// HTTP request-line parser: one byte per word, one status word per byte.
// Result words are registered. Throughput: one byte per cycle unless the skid
// register is full; the phase register updates once per byte and the skid
// register lets the next byte enter while a result waits downstream.
// Reset (rst, synchronous, active high) returns to the start phase, zeroes the
// offset and method/URI state, and empties the result and skid registers.
module http_request_line_parser
  import hrlp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  hrlp_in_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output hrlp_out_t result
);

  localparam logic [3:0] PH_START   = 4'd0;
  localparam logic [3:0] PH_METHOD  = 4'd1;
  localparam logic [3:0] PH_SP_URI  = 4'd2;
  localparam logic [3:0] PH_URI     = 4'd3;
  localparam logic [3:0] PH_PROTO   = 4'd4;
  localparam logic [3:0] PH_H       = 4'd5;
  localparam logic [3:0] PH_HT      = 4'd6;
  localparam logic [3:0] PH_HTT     = 4'd7;
  localparam logic [3:0] PH_HTTP    = 4'd8;
  localparam logic [3:0] PH_MAJOR   = 4'd9;
  localparam logic [3:0] PH_MAJ_DOT = 4'd10;
  localparam logic [3:0] PH_MINOR   = 4'd11;
  localparam logic [3:0] PH_TAIL    = 4'd12;
  localparam logic [3:0] PH_CR      = 4'd13;
  localparam logic [3:0] PH_TAIL_SP = 4'd14;
  localparam logic [3:0] PH_BAD     = 4'd15;

  // Parser state
  logic [3:0]              phase, phase_next;
  logic [OFFSET_WIDTH-1:0] byte_offset;
  logic [31:0]             method_letters, method_letters_next;
  logic [2:0]              method_length, method_length_next;
  logic [OFFSET_WIDTH-1:0] uri_begin, uri_begin_next;
  logic [OFFSET_WIDTH-1:0] uri_finish, uri_finish_next;
  logic [1:0]              method_code, method_code_next;

  // Result side: output register plus one skid entry
  hrlp_out_t skid;
  logic      skid_valid;

  logic                    accept;
  logic                    out_free;
  logic [3:0]              phase_cur;
  logic [OFFSET_WIDTH-1:0] pos;
  logic [7:0]              c;
  logic                    is_method_char;
  logic                    is_digit;
  logic                    done;
  logic [1:0]              match;
  logic [31:0]             pushed_letters;
  logic [2:0]              pushed_length;
  hrlp_out_t               res;

  // Stall upstream only while the skid entry holds a waiting word.
  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  assign c         = item.data_byte;
  assign phase_cur = item.restart ? PH_START : phase;
  assign pos       = item.restart ? '0 : byte_offset;

  assign is_method_char = (c inside {[CH_A:CH_Z]}) || (c == CH_UNDER);
  assign is_digit       = c inside {[CH_0:CH_9]};

  // Exact-length method compare against the letters gathered so far.
  always_comb begin
    if (method_length == 3'd3 && method_letters == LETTERS_GET) begin
      match = METHOD_GET;
    end else if (method_length == 3'd4 && method_letters == LETTERS_POST) begin
      match = METHOD_POST;
    end else if (method_length == 3'd4 && method_letters == LETTERS_HEAD) begin
      match = METHOD_HEAD;
    end else begin
      match = METHOD_UNKNOWN;
    end
  end

  // Append a method byte: only the first four are kept, the count saturates at 7.
  always_comb begin
    pushed_letters = method_letters;
    case (method_length)
      3'd0: pushed_letters = method_letters | {c, 24'd0};
      3'd1: pushed_letters = method_letters | {8'd0, c, 16'd0};
      3'd2: pushed_letters = method_letters | {16'd0, c, 8'd0};
      3'd3: pushed_letters = method_letters | {24'd0, c};
      default: pushed_letters = method_letters;
    endcase
    pushed_length = (method_length == 3'd7) ? method_length : method_length + 3'd1;
  end

  // Phase transition for one byte.
  always_comb begin
    phase_next          = phase_cur;
    method_letters_next = method_letters;
    method_length_next  = method_length;
    uri_begin_next      = uri_begin;
    uri_finish_next     = uri_finish;
    method_code_next    = method_code;
    done                = 1'b0;
    case (phase_cur)
      PH_START: begin
        if (c == CH_CR || c == CH_LF) begin
          phase_next = PH_START;
        end else if (!is_method_char) begin
          phase_next = PH_BAD;
        end else begin
          // Fresh method: first letter lands in the top byte.
          method_letters_next = {c, 24'd0};
          method_length_next  = 3'd1;
          phase_next          = PH_METHOD;
        end
      end
      PH_METHOD: begin
        if (c == CH_SP) begin
          method_code_next = match;
          phase_next       = (match != METHOD_UNKNOWN) ? PH_SP_URI : PH_BAD;
        end else if (is_method_char) begin
          method_letters_next = pushed_letters;
          method_length_next  = pushed_length;
        end else begin
          phase_next = PH_BAD;
        end
      end
      PH_SP_URI: begin
        if (c == CH_SLASH) begin
          uri_begin_next = pos;
          phase_next     = PH_URI;
        end else if (c != CH_SP) begin
          phase_next = PH_BAD;
        end
      end
      PH_URI: begin
        if (c == CH_SP) begin
          uri_finish_next = pos;
          phase_next      = PH_PROTO;
        end
      end
      PH_PROTO: begin
        if (c == CH_H) begin
          phase_next = PH_H;
        end else if (c != CH_SP) begin
          phase_next = PH_BAD;
        end
      end
      PH_H:       phase_next = (c == CH_T) ? PH_HT : PH_BAD;
      PH_HT:      phase_next = (c == CH_T) ? PH_HTT : PH_BAD;
      PH_HTT:     phase_next = (c == CH_P) ? PH_HTTP : PH_BAD;
      PH_HTTP:    phase_next = (c == CH_SLASH) ? PH_MAJOR : PH_BAD;
      PH_MAJOR:   phase_next = is_digit ? PH_MAJ_DOT : PH_BAD;
      PH_MAJ_DOT: begin
        if (c == CH_DOT) begin
          phase_next = PH_MINOR;
        end else if (!is_digit) begin
          phase_next = PH_BAD;
        end
      end
      PH_MINOR:   phase_next = is_digit ? PH_TAIL : PH_BAD;
      PH_TAIL: begin
        if (c == CH_CR) begin
          phase_next = PH_CR;
        end else if (c == CH_LF) begin
          done = 1'b1;
        end else if (c == CH_SP) begin
          phase_next = PH_TAIL_SP;
        end else if (!is_digit) begin
          phase_next = PH_BAD;
        end
      end
      PH_TAIL_SP: begin
        if (c == CH_CR) begin
          phase_next = PH_CR;
        end else if (c == CH_LF) begin
          done = 1'b1;
        end else if (c != CH_SP) begin
          phase_next = PH_BAD;
        end
      end
      PH_CR: begin
        if (c == CH_LF) begin
          done = 1'b1;
        end else begin
          phase_next = PH_BAD;
        end
      end
      default: phase_next = PH_BAD;
    endcase
    // A finished line goes back to the start phase; the offset keeps counting.
    if (done) begin
      phase_next = PH_START;
    end
  end

  // Result word: method and URI offsets only on a finished line.
  always_comb begin
    res = '0;
    if (done) begin
      res.status      = STATUS_DONE;
      res.method_kind = method_code_next;
      res.uri_first   = 16'(uri_begin_next);
      res.uri_last    = 16'(uri_finish_next);
    end else if (phase_next == PH_BAD) begin
      res.status = STATUS_INVALID;
    end else begin
      res.status = STATUS_MORE;
    end
  end

  // Advance parser state on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      byte_offset    <= '0;
      method_letters <= '0;
      method_length  <= '0;
      uri_begin      <= '0;
      uri_finish     <= '0;
      method_code    <= METHOD_UNKNOWN;
    end else if (accept) begin
      phase          <= phase_next;
      byte_offset    <= pos + OFFSET_WIDTH'(1);
      method_letters <= method_letters_next;
      method_length  <= method_length_next;
      uri_begin      <= uri_begin_next;
      uri_finish     <= uri_finish_next;
      method_code    <= method_code_next;
    end
  end

  // Output register and skid entry: drain the skid first, park a new word
  // in the skid when the output is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        result <= skid;
      end else if (accept) begin
        result <= res;
      end
    end else if (accept) begin
      skid <= res;
    end
  end

endmodule

// File: verif/hrlp_line_checker.sv
`timescale 1ns / 100ps
// Line checker: predicts the status word for every accepted byte word and compares results.
module hrlp_line_checker
  import hrlp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  logic      item_stall,
  input  hrlp_in_t  item,
  input  logic      result_valid,
  input  logic      result_stall,
  input  hrlp_out_t result,
  output int        mismatches,
  output int        pending
);

  typedef enum logic [3:0] {
    LINE_START, IN_METHOD, URI_GAP, IN_URI, PROTO_GAP, GOT_H, GOT_HT, GOT_HTT, GOT_HTTP,
    WANT_MAJOR, IN_MAJOR, WANT_MINOR, IN_MINOR, GOT_CR, TAIL_SPACE, LINE_BAD
  } line_phase_t;

  line_phase_t             line_phase;
  logic [OFFSET_WIDTH-1:0] next_offset;
  logic [31:0]             method_bytes;
  logic [2:0]              method_count;
  logic [OFFSET_WIDTH-1:0] slash_pos;
  logic [OFFSET_WIDTH-1:0] uri_stop;
  logic [1:0]              method_seen;
  hrlp_out_t               status_due[$];

  function automatic logic method_char(logic [7:0] c);
    return (c >= CH_A && c <= CH_Z) || c == CH_UNDER;
  endfunction

  function automatic logic digit(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  // Keep the first four method letters, first one on top; count saturates.
  function automatic void take_letter(logic [7:0] c);
    if (method_count < 3'd4) method_bytes[8 * (3 - method_count) +: 8] = c;
    if (method_count != 3'd7) method_count = method_count + 3'd1;
  endfunction

  function automatic hrlp_out_t predict_word(hrlp_in_t w);
    hrlp_out_t               word;
    logic [7:0]              c;
    logic [OFFSET_WIDTH-1:0] pos;
    logic                    done;
    c    = w.data_byte;
    done = 1'b0;
    if (w.restart) begin
      line_phase  = LINE_START;
      next_offset = '0;
    end
    pos = next_offset;
    case (line_phase)
      LINE_START: begin
        if (c != CH_CR && c != CH_LF) begin
          if (method_char(c)) begin
            method_bytes = '0;
            method_count = '0;
            take_letter(c);
            line_phase = IN_METHOD;
          end else begin
            line_phase = LINE_BAD;
          end
        end
      end
      IN_METHOD: begin
        if (c == CH_SP) begin
          if (method_count == 3'd3 && method_bytes == LETTERS_GET) method_seen = METHOD_GET;
          else if (method_count == 3'd4 && method_bytes == LETTERS_POST)
            method_seen = METHOD_POST;
          else if (method_count == 3'd4 && method_bytes == LETTERS_HEAD)
            method_seen = METHOD_HEAD;
          else method_seen = METHOD_UNKNOWN;
          line_phase = (method_seen == METHOD_UNKNOWN) ? LINE_BAD : URI_GAP;
        end else if (method_char(c)) begin
          take_letter(c);
        end else begin
          line_phase = LINE_BAD;
        end
      end
      URI_GAP: begin
        if (c == CH_SLASH) begin
          slash_pos  = pos;
          line_phase = IN_URI;
        end else if (c != CH_SP) begin
          line_phase = LINE_BAD;
        end
      end
      IN_URI: begin
        if (c == CH_SP) begin
          uri_stop   = pos;
          line_phase = PROTO_GAP;
        end
      end
      PROTO_GAP: begin
        if (c == CH_H) line_phase = GOT_H;
        else if (c != CH_SP) line_phase = LINE_BAD;
      end
      GOT_H:      line_phase = (c == CH_T) ? GOT_HT : LINE_BAD;
      GOT_HT:     line_phase = (c == CH_T) ? GOT_HTT : LINE_BAD;
      GOT_HTT:    line_phase = (c == CH_P) ? GOT_HTTP : LINE_BAD;
      GOT_HTTP:   line_phase = (c == CH_SLASH) ? WANT_MAJOR : LINE_BAD;
      WANT_MAJOR: line_phase = digit(c) ? IN_MAJOR : LINE_BAD;
      IN_MAJOR: begin
        if (c == CH_DOT) line_phase = WANT_MINOR;
        else if (!digit(c)) line_phase = LINE_BAD;
      end
      WANT_MINOR: line_phase = digit(c) ? IN_MINOR : LINE_BAD;
      IN_MINOR: begin
        if (c == CH_CR) line_phase = GOT_CR;
        else if (c == CH_LF) done = 1'b1;
        else if (c == CH_SP) line_phase = TAIL_SPACE;
        else if (!digit(c)) line_phase = LINE_BAD;
      end
      TAIL_SPACE: begin
        if (c == CH_CR) line_phase = GOT_CR;
        else if (c == CH_LF) done = 1'b1;
        else if (c != CH_SP) line_phase = LINE_BAD;
      end
      GOT_CR: begin
        if (c == CH_LF) done = 1'b1;
        else line_phase = LINE_BAD;
      end
      default: line_phase = LINE_BAD;
    endcase
    if (done) line_phase = LINE_START;
    word = '0;
    if (line_phase == LINE_BAD) begin
      word.status = STATUS_INVALID;
    end else if (done) begin
      word.status      = STATUS_DONE;
      word.method_kind = method_seen;
      word.uri_first   = 16'(slash_pos);
      word.uri_last    = 16'(uri_stop);
    end else begin
      word.status = STATUS_MORE;
    end
    next_offset = pos + 1'b1;
    return word;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    hrlp_out_t want;
    if (rst) begin
      line_phase   = LINE_START;
      next_offset  = '0;
      method_bytes = '0;
      method_count = '0;
      slash_pos    = '0;
      uri_stop     = '0;
      method_seen  = METHOD_UNKNOWN;
      status_due.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (status_due.size() == 0) begin
          mismatches++;
          $error("status word with no byte word outstanding");
        end else begin
          want = status_due.pop_front();
          check_field("status", 32'(want.status), 32'(result.status));
          check_field("method_kind", 32'(want.method_kind), 32'(result.method_kind));
          check_field("uri_first", 32'(want.uri_first), 32'(result.uri_first));
          check_field("uri_last", 32'(want.uri_last), 32'(result.uri_last));
        end
      end
      if (item_valid && !item_stall) status_due.push_back(predict_word(item));
    end
    pending = status_due.size();
  end

endmodule

// File: verif/http_request_line_parser_tb.sv
`timescale 1ns / 100ps
// Testbench top: drives byte words into the request-line parser and gives the verdict.
module http_request_line_parser_tb;
  import hrlp_pkg::*;

  localparam int RANDOM_WORDS  = 1650;
  // Slowest correct run: about 1700 words, each behind at most the longest gap and
  // the longest stall; allow several times that.
  localparam int LIMIT_CYCLES  = 1_000_000;
  // Result words are registered behind their bytes; leave settle time for stray words.
  localparam int SETTLE_CYCLES = 8;

  logic      clk          = 1'b0;
  logic      rst          = 1'b1;
  logic      item_valid   = 1'b0;
  logic      item_stall;
  hrlp_in_t  item         = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  hrlp_out_t result;

  int         mismatches;
  int         pending;
  int         cycle_count  = 0;
  int         words_sent   = 0;
  bit         back_to_back = 1'b0;
  logic [7:0] line_bytes[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  http_request_line_parser uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  hrlp_line_checker line_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: open for a while, then stall. Mostly short stalls, some long ones,
  // and now and then a long open stretch so the parser runs at full rate.
  initial begin
    int n;
    forever begin
      if ($urandom_range(0, 9) == 0) n = $urandom_range(40, 200);
      else n = $urandom_range(1, 6);
      repeat (n) @(posedge clk);
      result_stall <= 1'b1;
      if ($urandom_range(0, 9) == 0) n = $urandom_range(10, 40);
      else n = $urandom_range(1, 3);
      repeat (n) @(posedge clk);
      result_stall <= 1'b0;
    end
  end

  // Idle cycles before the next word: none in back-to-back bursts, else mostly short.
  function automatic int pick_gap();
    int r;
    if (back_to_back) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Present one byte word and hold it until the parser takes it. Leave valid high
  // on return so the next word can follow without a bubble.
  task automatic send_word(input logic [7:0] b, input logic rs);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= {b, rs};
    do @(posedge clk); while (item_stall);
    words_sent++;
  endtask

  // Send the staged line; only its first word may carry restart.
  task automatic send_line(input logic rs);
    for (int i = 0; i < line_bytes.size(); i++) send_word(line_bytes[i], rs && i == 0);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endtask

  function automatic logic [7:0] uri_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_SP);
    return b;
  endfunction

  function automatic logic [7:0] method_letter();
    int v;
    v = $urandom_range(0, 26);
    return (v == 26) ? CH_UNDER : CH_A + 8'(v);
  endfunction

  // Hold the sender until every predicted status word has come back.
  task automatic wait_for_results();
    item_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // Stage one request line: mostly well formed with random content. Flag it
  // dirty when it is likely to leave the parser in the invalid phase.
  task automatic build_request(output bit dirty);
    int n;
    int k;
    line_bytes.delete();
    dirty = 1'b0;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) line_bytes.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
    k = $urandom_range(0, 19);
    if (k < 12) begin
      case ($urandom_range(0, 2))
        0:       add_text("GET");
        1:       add_text("POST");
        default: add_text("HEAD");
      endcase
    end else if (k < 16) begin
      // Near misses: right letters with the wrong length, or a wrong letter or two.
      dirty = 1'b1;
      case ($urandom_range(0, 9))
        0:       add_text("GE");
        1:       add_text("GETS");
        2:       add_text("HEA");
        3:       add_text("HEADER");
        4:       add_text("POS");
        5:       add_text("POSTS");
        6:       add_text("PUT");
        7:       add_text("HEAP");
        8:       add_text("_GET");
        default: add_text("GET_ME_THE_PAGE");
      endcase
    end else begin
      dirty = 1'b1;
      repeat ($urandom_range(1, 9)) line_bytes.push_back(method_letter());
    end
    repeat ($urandom_range(1, 3)) line_bytes.push_back(CH_SP);
    line_bytes.push_back(CH_SLASH);
    repeat ($urandom_range(0, 8)) line_bytes.push_back(uri_byte());
    repeat ($urandom_range(1, 3)) line_bytes.push_back(CH_SP);
    add_text("HTTP/");
    repeat ($urandom_range(1, 3)) line_bytes.push_back(CH_0 + 8'($urandom_range(0, 9)));
    line_bytes.push_back(CH_DOT);
    repeat ($urandom_range(1, 3)) line_bytes.push_back(CH_0 + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 2)) line_bytes.push_back(CH_SP);
    if ($urandom_range(0, 1)) line_bytes.push_back(CH_CR);
    line_bytes.push_back(CH_LF);
    // Corrupt one byte now and then, or cut the line short.
    if ($urandom_range(0, 5) == 0) begin
      k = $urandom_range(0, line_bytes.size() - 1);
      line_bytes[k] = 8'($urandom_range(0, 255));
      dirty = 1'b1;
    end
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, line_bytes.size() - 1);
      while (line_bytes.size() > n) line_bytes.delete(line_bytes.size() - 1);
      dirty = 1'b1;
    end
  endtask

  initial begin
    bit dirty;
    bit drained;
    bit restart_first;
    int random_start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: invalid first byte with all ones, sticky invalid on all zeros,
    // restart into leading CR/LF, then a minimal GET ended by a bare LF.
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(CH_LF, 1'b1);
    send_word(CH_CR, 1'b0);
    line_bytes.delete();
    add_text("GET / HTTP/1.0");
    line_bytes.push_back(CH_LF);
    send_line(1'b0);

    // Random: request lines with random content, some noise bursts. Restart after
    // a dirty line most of the time so later lines get past the first phases.
    dirty        = 1'b0;
    drained      = 1'b0;
    random_start = words_sent;
    while (words_sent - random_start < RANDOM_WORDS) begin
      back_to_back = ($urandom_range(0, 4) == 0);
      if (!drained && words_sent - random_start >= RANDOM_WORDS / 2) begin
        wait_for_results();
        drained = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 12))
          send_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        dirty = 1'b1;
      end else begin
        restart_first = dirty ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 3) == 0);
        build_request(dirty);
        send_line(restart_first);
      end
    end

    // Drain, then wait SETTLE_CYCLES for stray words to show up.
    item_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
